// File: rtl/croc_pkg.sv
// ----------------------------------------------------------------------------
// croc_pkg
// Types and constants for the clock replacement object cache: item
// structs for both channels, result kinds and configuration register map.
// ----------------------------------------------------------------------------
`default_nettype none

package croc_pkg;

    localparam int unsigned KEY_W      = 64;
    localparam int unsigned SIZE_W     = 20;
    localparam int unsigned CAP_W      = 24;
    localparam int unsigned BYTES_W    = 25;
    localparam int unsigned SLOT_OUT_W = 6;
    localparam int unsigned CFG_IDX_W  = 8;

    localparam logic [CAP_W-1:0]  CAP_RESET     = 24'd1049000;
    localparam logic [SIZE_W-1:0] MAX_OBJ_RESET = 20'd102400;

    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_OBJ  = 8'd1;

    localparam logic CMD_LOOKUP = 1'b0;
    localparam logic CMD_INSERT = 1'b1;

    localparam logic [1:0] KIND_LOOKUP = 2'd0;
    localparam logic [1:0] KIND_EVICT  = 2'd1;
    localparam logic [1:0] KIND_PLACED = 2'd2;
    localparam logic [1:0] KIND_REJECT = 2'd3;

    typedef struct packed {
        logic              cmd;
        logic [KEY_W-1:0]  key;
        logic [SIZE_W-1:0] obj_size;
    } t_in_item;

    typedef struct packed {
        logic [1:0]            kind;
        logic                  hit;
        logic [SLOT_OUT_W-1:0] slot;
        logic [KEY_W-1:0]      entry_key;
        logic [SIZE_W-1:0]     entry_size;
        logic                  last;
    } t_out_item;

endpackage

`default_nettype wire

// File: rtl/clock_replacement_object_cache.sv
// ----------------------------------------------------------------------------
// clock_replacement_object_cache
// Slot table metadata for an object cache with second-chance clock
// replacement: lookup by key, insert with eviction sweep, byte budget.
// ----------------------------------------------------------------------------
// Keys and sizes sit in a single-port synchronous memory, valid and
// referenced bits in flip-flops. Every item is accepted in the idle state.
// A lookup then scans the key memory one slot per cycle from slot 0 and
// stops on the first valid match or after the last slot; its result then
// waits in the emit state for the output register. An insert steps the
// hand of the clock sweep while bytes or slots run short, clearing set
// referenced bits and evicting each unreferenced entry with a result of
// its own, then steps on to a free slot and places the entry; a rejected
// insert goes straight to its result. Each result occupies the output
// register until taken; the next item is accepted once the last result of
// the current one is in that register. No clearing pass is needed after reset.
`default_nettype none

module clock_replacement_object_cache #(
    parameter int unsigned NUM_SLOTS = 16,
    parameter int unsigned KEY_WIDTH = 64
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_in_valid,
    output logic                       o_in_ready,
    input  croc_pkg::t_in_item         i_in_item,
    output logic                       o_out_valid,
    input  wire                        i_out_ready,
    output croc_pkg::t_out_item        o_out_item,
    input  wire                        i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire [croc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire [croc_pkg::CAP_W-1:0]  i_cfg_data
);
    import croc_pkg::*;

    localparam int unsigned SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int unsigned CW = $clog2(NUM_SLOTS + 1);
    localparam logic [SW-1:0] LAST_SLOT = SW'(NUM_SLOTS - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(NUM_SLOTS);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_LOOK  = 3'd1;
    localparam logic [2:0] S_SWEEP = 3'd2;
    localparam logic [2:0] S_EVICT = 3'd3;
    localparam logic [2:0] S_EMIT  = 3'd4;

    logic [KEY_WIDTH-1:0] r_mem_key [NUM_SLOTS];
    logic [SIZE_W-1:0]    r_mem_size [NUM_SLOTS];
    logic [KEY_WIDTH-1:0] r_key_q;
    logic [SIZE_W-1:0]    r_size_q;

    logic [2:0]           r_state, n_state;
    logic [2:0]           r_ret, n_ret;
    logic [SW-1:0]        r_idx, n_idx;
    logic [SW-1:0]        r_ridx, n_ridx;
    logic                 r_pend, n_pend;
    logic [SW-1:0]        r_hand, n_hand;
    logic [NUM_SLOTS-1:0] r_valid, n_valid;
    logic [NUM_SLOTS-1:0] r_ref, n_ref;
    logic [BYTES_W-1:0]   r_used_bytes, n_used_bytes;
    logic [CW-1:0]        r_used_slots, n_used_slots;
    logic [CAP_W-1:0]     r_cap, n_cap;
    logic [SIZE_W-1:0]    r_max_obj, n_max_obj;
    logic                 r_out_valid, n_out_valid;
    t_out_item            r_out, n_out;
    t_out_item            r_res, n_res;
    logic [KEY_WIDTH-1:0] r_key, n_key;
    logic [SIZE_W-1:0]    r_size, n_size;

    logic [SW-1:0]        w_rd_addr;
    logic                 w_we;
    logic                 w_out_free;
    logic                 w_need;
    logic [SW-1:0]        w_hand_inc;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    assign w_rd_addr  = (r_state == S_LOOK) ? r_idx : r_hand;
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_hand_inc = (r_hand == LAST_SLOT) ? '0 : r_hand + 1'b1;
    assign w_need     = (r_used_slots != '0) &&
                        (((BYTES_W + 1)'(r_used_bytes) + (BYTES_W + 1)'(r_size) >
                          (BYTES_W + 1)'(r_cap)) || (r_used_slots >= FULL_CNT));

    always_comb begin
        n_state      = r_state;
        n_ret        = r_ret;
        n_idx        = r_idx;
        n_ridx       = r_ridx;
        n_pend       = r_pend;
        n_hand       = r_hand;
        n_valid      = r_valid;
        n_ref        = r_ref;
        n_used_bytes = r_used_bytes;
        n_used_slots = r_used_slots;
        n_cap        = r_cap;
        n_max_obj    = r_max_obj;
        n_out_valid  = r_out_valid;
        n_out        = r_out;
        n_res        = r_res;
        n_key        = r_key;
        n_size       = r_size;
        w_we         = 1'b0;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        if (i_cfg_valid) begin
            if (i_cfg_index == CFG_CAPACITY) begin
                n_cap = i_cfg_data;
            end else if (i_cfg_index == CFG_MAX_OBJ) begin
                n_max_obj = i_cfg_data[SIZE_W-1:0];
            end
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_key  = i_in_item.key[KEY_WIDTH-1:0];
                    n_size = i_in_item.obj_size;
                    if (i_in_item.cmd == CMD_LOOKUP) begin
                        n_idx   = '0;
                        n_pend  = 1'b0;
                        n_state = S_LOOK;
                    end else if ((i_in_item.obj_size > r_max_obj) ||
                                 (CAP_W'(i_in_item.obj_size) > r_cap)) begin
                        n_res.kind       = KIND_REJECT;
                        n_res.hit        = 1'b0;
                        n_res.slot       = '0;
                        n_res.entry_key  = KEY_W'(i_in_item.key[KEY_WIDTH-1:0]);
                        n_res.entry_size = '0;
                        n_res.last       = 1'b1;
                        n_ret            = S_IDLE;
                        n_state          = S_EMIT;
                    end else begin
                        n_state = S_SWEEP;
                    end
                end
            end
            S_LOOK: begin
                n_pend = 1'b1;
                n_ridx = r_idx;
                if (r_idx != LAST_SLOT) begin
                    n_idx = r_idx + 1'b1;
                end
                if (r_pend) begin
                    n_res.kind      = KIND_LOOKUP;
                    n_res.entry_key = KEY_W'(r_key);
                    n_res.last      = 1'b1;
                    if (r_valid[r_ridx] && (r_key_q == r_key)) begin
                        n_ref[r_ridx]    = 1'b1;
                        n_res.hit        = 1'b1;
                        n_res.slot       = SLOT_OUT_W'(r_ridx);
                        n_res.entry_size = r_size_q;
                        n_ret            = S_IDLE;
                        n_state          = S_EMIT;
                    end else if (r_ridx == LAST_SLOT) begin
                        n_res.hit        = 1'b0;
                        n_res.slot       = '0;
                        n_res.entry_size = '0;
                        n_ret            = S_IDLE;
                        n_state          = S_EMIT;
                    end
                end
            end
            S_SWEEP: begin
                if (w_need) begin
                    if (!r_valid[r_hand]) begin
                        n_hand = w_hand_inc;
                    end else if (r_ref[r_hand]) begin
                        n_ref[r_hand] = 1'b0;
                        n_hand        = w_hand_inc;
                    end else begin
                        n_state = S_EVICT;
                    end
                end else if (r_valid[r_hand]) begin
                    n_hand = w_hand_inc;
                end else begin
                    w_we             = 1'b1;
                    n_valid[r_hand]  = 1'b1;
                    n_ref[r_hand]    = 1'b1;
                    n_used_bytes     = r_used_bytes + BYTES_W'(r_size);
                    n_used_slots     = r_used_slots + 1'b1;
                    n_res.kind       = KIND_PLACED;
                    n_res.hit        = 1'b0;
                    n_res.slot       = SLOT_OUT_W'(r_hand);
                    n_res.entry_key  = KEY_W'(r_key);
                    n_res.entry_size = r_size;
                    n_res.last       = 1'b1;
                    n_ret            = S_IDLE;
                    n_state          = S_EMIT;
                end
            end
            S_EVICT: begin
                n_valid[r_hand]  = 1'b0;
                n_used_bytes     = r_used_bytes - BYTES_W'(r_size_q);
                n_used_slots     = r_used_slots - 1'b1;
                n_res.kind       = KIND_EVICT;
                n_res.hit        = 1'b0;
                n_res.slot       = SLOT_OUT_W'(r_hand);
                n_res.entry_key  = KEY_W'(r_key_q);
                n_res.entry_size = r_size_q;
                n_res.last       = 1'b0;
                n_ret            = S_SWEEP;
                n_state          = S_EMIT;
            end
            S_EMIT: begin
                if (w_out_free) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = r_ret;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_key_q  <= r_mem_key[w_rd_addr];
        r_size_q <= r_mem_size[w_rd_addr];
        if (w_we) begin
            r_mem_key[r_hand]  <= r_key;
            r_mem_size[r_hand] <= r_size;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ret  <= n_ret;
        r_idx  <= n_idx;
        r_ridx <= n_ridx;
        r_out  <= n_out;
        r_res  <= n_res;
        r_key  <= n_key;
        r_size <= n_size;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_pend       <= 1'b0;
            r_hand       <= '0;
            r_valid      <= '0;
            r_ref        <= '0;
            r_used_bytes <= '0;
            r_used_slots <= '0;
            r_cap        <= CAP_RESET;
            r_max_obj    <= MAX_OBJ_RESET;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_pend       <= n_pend;
            r_hand       <= n_hand;
            r_valid      <= n_valid;
            r_ref        <= n_ref;
            r_used_bytes <= n_used_bytes;
            r_used_slots <= n_used_slots;
            r_cap        <= n_cap;
            r_max_obj    <= n_max_obj;
            r_out_valid  <= n_out_valid;
        end
    end

`ifndef NO_ASSERTIONS
    a_slot_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_valid) == int'(r_used_slots))
        else $error("slot count does not match valid bits");

    a_hand_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hand <= LAST_SLOT)
        else $error("clock hand out of range");

    a_evict_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.kind == KIND_EVICT)) |-> !r_out.last)
        else $error("eviction notice marked as final item");

    a_place_sets_bits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |=> (r_valid[$past(r_hand)] && r_ref[$past(r_hand)]))
        else $error("placed slot not valid and referenced");

    a_evict_from_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EVICT) |-> (r_valid[r_hand] && !r_ref[r_hand]))
        else $error("eviction of an invalid or referenced slot");
`endif

endmodule

`default_nettype wire
